// ===== rtl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch LED sequencer package
// Shared types and codes for the touch to LED expander sequencer.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [6:0] DevAddrReset = 7'h20;

   localparam logic REQ_TOUCH    = 1'b0;
   localparam logic REQ_TRANSFER = 1'b1;

   localparam logic [1:0] KIND_PROBE = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_PRE_PROBE  = 2'd1;
   localparam logic [1:0] PH_WRITE      = 2'd2;
   localparam logic [1:0] PH_POST_PROBE = 2'd3;

   localparam logic [7:0] REG_DIR_A   = 8'h00;
   localparam logic [7:0] REG_DIR_B   = 8'h01;
   localparam logic [7:0] REG_LATCH_A = 8'h14;
   localparam logic [7:0] REG_LATCH_B = 8'h15;

   localparam logic [7:0] DIR_ALL_OUT = 8'h00;

   typedef struct packed {
      logic       req_type;
      logic [3:0] button_detect;
      logic       scroller_detect;
      logic [7:0] scroller_position;
      logic       transfer_ok;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] command_kind;
      logic [6:0] target_address;
      logic [7:0] register_index;
      logic [7:0] register_value;
   } rsp_beat_type;

endpackage

// ===== rtl/tle_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying touch results and transfer completions.
// ----------------------------------------------------------------------------
interface tle_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [3:0] button_detect;
   logic       scroller_detect;
   logic [7:0] scroller_position;
   logic       transfer_ok;

   modport source (
      output valid, req_type, button_detect, scroller_detect, scroller_position,
         transfer_ok,
      input  ready
   );
   modport sink (
      input  valid, req_type, button_detect, scroller_detect, scroller_position,
         transfer_ok,
      output ready
   );
endinterface

// ===== rtl/tle_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying bus commands and completion notices.
// ----------------------------------------------------------------------------
interface tle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] command_kind;
   logic [6:0] target_address;
   logic [7:0] register_index;
   logic [7:0] register_value;

   modport source (
      output valid, command_kind, target_address, register_index, register_value,
      input  ready
   );
   modport sink (
      input  valid, command_kind, target_address, register_index, register_value,
      output ready
   );
endinterface

// ===== rtl/tle_csr.sv =====
// ----------------------------------------------------------------------------
// Sequencer register block
// APB-style slave holding the expander bus address.
// ----------------------------------------------------------------------------
module tle_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tle_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [tle_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [tle_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready,
   output logic [6:0]                        device_address
);
   import tle_pkg::*;

   logic [6:0] dev_addr_ff;
   logic [6:0] dev_addr_in;
   logic       sel_dev_addr;

   assign sel_dev_addr = (csr_paddr[2] == 1'b0);
   assign csr_pready   = 1'b1;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_dev_addr) begin
         dev_addr_in = csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= DevAddrReset;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   assign csr_prdata     = sel_dev_addr ? {{(CsrDataWidth-7){1'b0}}, dev_addr_ff}
                                        : '0;
   assign device_address = dev_addr_ff;
endmodule

// ===== rtl/tle_seq.sv =====
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the update state and turns each accepted beat into at most one command.
// ----------------------------------------------------------------------------
module tle_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  tle_pkg::req_beat_type req_beat,
   input  logic [6:0]            device_address,
   output logic                  has_result,
   output tle_pkg::rsp_beat_type rsp_beat
);
   import tle_pkg::*;

   logic [1:0] phase_ff,        phase_in;
   logic       port_a_set_ff,   port_a_set_in;
   logic       port_b_set_ff,   port_b_set_in;
   logic       buttons_sent_ff, buttons_sent_in;
   logic       slider_sent_ff,  slider_sent_in;
   logic [7:0] button_byte_ff,  button_byte_in;
   logic [7:0] slider_byte_ff,  slider_byte_in;

   logic [1:0] kind;
   logic [7:0] reg_index;
   logic [7:0] reg_value;
   logic [7:0] new_slider;
   logic [7:0] new_buttons;

   assign new_buttons = {req_beat.button_detect[0], req_beat.button_detect[1],
                         req_beat.button_detect[2], req_beat.button_detect[3], 4'b0000};
   assign new_slider  = req_beat.scroller_detect
                      ? 8'(8'hFF << (3'd7 - req_beat.scroller_position[7:5])) : 8'h00;

   always_comb begin
      phase_in        = phase_ff;
      port_a_set_in   = port_a_set_ff;
      port_b_set_in   = port_b_set_ff;
      buttons_sent_in = buttons_sent_ff;
      slider_sent_in  = slider_sent_ff;
      button_byte_in  = button_byte_ff;
      slider_byte_in  = slider_byte_ff;
      has_result      = 1'b0;
      kind            = KIND_PROBE;
      reg_index       = 8'h00;
      reg_value       = 8'h00;
      if (accept) begin
         if (req_beat.req_type == REQ_TOUCH) begin
            if (phase_ff == PH_IDLE) begin
               button_byte_in  = new_buttons;
               slider_byte_in  = new_slider;
               buttons_sent_in = 1'b0;
               slider_sent_in  = 1'b0;
               phase_in        = PH_PRE_PROBE;
               has_result      = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  has_result = 1'b0;
               end
               PH_PRE_PROBE: begin
                  has_result = 1'b1;
                  if (req_beat.transfer_ok) begin
                     phase_in = PH_WRITE;
                     kind     = KIND_WRITE;
                     priority if (!port_a_set_ff) begin
                        port_a_set_in = 1'b1;
                        reg_index     = REG_DIR_A;
                        reg_value     = DIR_ALL_OUT;
                     end else if (!port_b_set_ff) begin
                        port_b_set_in = 1'b1;
                        reg_index     = REG_DIR_B;
                        reg_value     = DIR_ALL_OUT;
                     end else if (!buttons_sent_ff) begin
                        buttons_sent_in = 1'b1;
                        reg_index       = REG_LATCH_A;
                        reg_value       = button_byte_ff;
                     end else begin
                        slider_sent_in = 1'b1;
                        reg_index      = REG_LATCH_B;
                        reg_value      = slider_byte_ff;
                     end
                  end
               end
               PH_WRITE: begin
                  has_result = 1'b1;
                  phase_in   = req_beat.transfer_ok ? PH_POST_PROBE : PH_PRE_PROBE;
               end
               PH_POST_PROBE: begin
                  has_result = 1'b1;
                  if (req_beat.transfer_ok) begin
                     if (slider_sent_ff) begin
                        phase_in = PH_IDLE;
                        kind     = KIND_DONE;
                     end else begin
                        phase_in = PH_PRE_PROBE;
                     end
                  end
               end
               default: begin
                  has_result = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         port_a_set_ff   <= 1'b0;
         port_b_set_ff   <= 1'b0;
         buttons_sent_ff <= 1'b0;
         slider_sent_ff  <= 1'b0;
         button_byte_ff  <= 8'h00;
         slider_byte_ff  <= 8'h00;
      end else begin
         phase_ff        <= phase_in;
         port_a_set_ff   <= port_a_set_in;
         port_b_set_ff   <= port_b_set_in;
         buttons_sent_ff <= buttons_sent_in;
         slider_sent_ff  <= slider_sent_in;
         button_byte_ff  <= button_byte_in;
         slider_byte_ff  <= slider_byte_in;
      end
   end

   assign rsp_beat.command_kind   = kind;
   assign rsp_beat.target_address = (kind == KIND_DONE) ? 7'd0 : device_address;
   assign rsp_beat.register_index = reg_index;
   assign rsp_beat.register_value = reg_value;

   a_slider_after_setup: assert property (@(posedge clock) disable iff (reset)
      slider_sent_ff |-> (buttons_sent_ff && port_a_set_ff && port_b_set_ff))
      else $error("Slider latch marked sent before the earlier writes.");

   a_touch_starts_update: assert property (@(posedge clock) disable iff (reset)
      (accept && req_beat.req_type == REQ_TOUCH && phase_ff == PH_IDLE)
      |=> (phase_ff == PH_PRE_PROBE && !slider_sent_ff && !buttons_sent_ff))
      else $error("Touch beat while idle did not start an update.");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (has_result && kind == KIND_DONE) |=> (phase_ff == PH_IDLE))
      else $error("Completion notice issued without returning to idle.");

   a_idle_transfer_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_beat.req_type == REQ_TRANSFER && phase_ff == PH_IDLE)
      |-> !has_result)
      else $error("Transfer beat while idle produced a command.");
endmodule

// ===== rtl/tle_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// Response output stage
// Output register with a skid entry so the request side keeps flowing.
// ----------------------------------------------------------------------------
module tle_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tle_pkg::rsp_beat_type push_beat,
   output logic                  can_accept,
   tle_rsp_if.source             rsp_chan
);
   import tle_pkg::*;

   logic         out_valid_ff,  out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type out_beat_ff,   out_beat_in;
   rsp_beat_type skid_beat_ff,  skid_beat_in;
   logic         pop;

   assign pop = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_beat_in  = skid_beat_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_beat_in   = skid_beat_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_beat_in  = push_beat;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_beat_ff  <= out_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

   assign can_accept              = !skid_valid_ff;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.command_kind   = out_beat_ff.command_kind;
   assign rsp_chan.target_address = out_beat_ff.target_address;
   assign rsp_chan.register_index = out_beat_ff.register_index;
   assign rsp_chan.register_value = out_beat_ff.register_value;
endmodule

// ===== rtl/touch_to_led_expander_sequencer.sv =====
// ----------------------------------------------------------------------------
// Touch to LED expander sequencer
// Turns touch results and bus completions into LED expander bus commands.
//
// The request channel carries touch results and bus transfer completions;
// the response channel carries probe and register write commands for the
// expander and a completion notice at the end of each update. The APB port
// holds the expander's seven-bit bus address at offset 0.
// Each request beat is handled in the cycle it is accepted; its command,
// if any, is registered in the response output stage. A new request beat
// can be taken every cycle while the skid entry is empty, since the state
// update is one pass of logic between the state and response registers.
// The response side has an output register and one skid entry: while the
// receiver stalls, one more command can be absorbed, after which request
// ready drops until the skid entry drains.
// Reset returns the sequencer to idle, forgets that the port directions were
// set, clears the latched button and slider bytes and sets the bus address
// to 0x20. No response is pending after reset.
// ----------------------------------------------------------------------------
module touch_to_led_expander_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   tle_req_if.sink                           req_chan,
   tle_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tle_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [tle_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [tle_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import tle_pkg::*;

   logic         accept;
   logic         can_accept;
   logic         has_result;
   logic [6:0]   device_address;
   req_beat_type req_beat;
   rsp_beat_type rsp_beat;

   assign req_chan.ready             = can_accept;
   assign accept                     = req_chan.valid && can_accept;
   assign req_beat.req_type          = req_chan.req_type;
   assign req_beat.button_detect     = req_chan.button_detect;
   assign req_beat.scroller_detect   = req_chan.scroller_detect;
   assign req_beat.scroller_position = req_chan.scroller_position;
   assign req_beat.transfer_ok       = req_chan.transfer_ok;

   tle_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .device_address (device_address)
   );

   tle_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_beat       (req_beat),
      .device_address (device_address),
      .has_result     (has_result),
      .rsp_beat       (rsp_beat)
   );

   tle_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (has_result),
      .push_beat  (rsp_beat),
      .can_accept (can_accept),
      .rsp_chan   (rsp_chan)
   );
endmodule
